// ===== hw/rtl/palette_slot_allocator_unit_macros.svh =====
// Assertion macros for the palette slot allocator.
// Expects aclk and aresetn in the scope of the use.
`ifndef PALETTE_SLOT_ALLOCATOR_UNIT_MACROS_SVH
`define PALETTE_SLOT_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication
`define PSA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/psa_pkg.sv =====
// Shared types and constants of the palette slot allocator.
// No dependencies.
`default_nettype none

package psa_pkg;

    localparam int ACTION_W = 2;
    localparam int SIZE_W   = 10;
    localparam int BASE_W   = 9;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NOP   = 2'd3
    } psa_action_t;

    localparam logic STAT_DONE    = 1'b0;
    localparam logic STAT_NOSPACE = 1'b1;

endpackage

`default_nettype wire

// ===== hw/rtl/palette_slot_allocator_unit.sv =====
// Palette slot allocator top level: FSM, scan datapath and the two stores.
// Depends on psa_pkg, psa_ram and palette_slot_allocator_unit_macros.svh.
//
//  channel | direction | ports                                   | handshake
//  --------+-----------+-----------------------------------------+------------------
//  request | in        | s_action s_bank s_request_size s_slot_index | s_valid/s_ready
//  result  | out       | m_status m_base_slot                    | m_valid/m_ready
//
// Allocate: the scan reads one slot per cycle from the used RAM until a grant or a
// no-space answer, then each granted slot is marked in turn, then the result is sent.
// Free: the recorded run length is read from the size RAM, then each slot of the run is
// cleared. Clear: both stores are wiped. After reset they are wiped with s_ready low.
// One request at a time; a finished result waits in the output register and the next
// request can be taken meanwhile; its result then holds the FSM until that beat leaves.
`default_nettype none
`include "palette_slot_allocator_unit_macros.svh"

module palette_slot_allocator_unit
    import psa_pkg::*;
#(
    parameter int SLOTS = 512
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [ACTION_W-1:0] s_action,
    input  wire logic              s_bank,
    input  wire logic [SIZE_W-1:0] s_request_size,
    input  wire logic [BASE_W-1:0] s_slot_index,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_status,
    output logic [BASE_W-1:0]      m_base_slot
);

    localparam int IW    = $clog2(SLOTS + 1);
    localparam int AW    = $clog2(2 * SLOTS);
    localparam int LW    = (IW > SIZE_W) ? IW : SIZE_W;
    localparam int DEPTH = 2 * SLOTS;

    typedef enum logic [2:0] {
        ST_WIPE,
        ST_IDLE,
        ST_SCAN,
        ST_MARK,
        ST_FREQ,
        ST_FGET,
        ST_RESP
    } state_t;

    state_t state_reg, state_next;

    logic              m_valid_reg, m_valid_next;
    logic              m_status_reg, m_status_next;
    logic [BASE_W-1:0] m_base_reg, m_base_next;

    logic              wipe_rsp_reg, wipe_rsp_next;
    logic              mark_val_reg, mark_val_next;
    logic [SIZE_W-1:0] len_reg, len_next;
    logic [AW-1:0]     off_reg, off_next;
    logic [AW-1:0]     mptr_reg, mptr_next;
    logic [SIZE_W-1:0] mcnt_reg, mcnt_next;
    logic [IW-1:0]     scan_idx_reg, scan_idx_next;
    logic              pend_reg, pend_next;
    logic [IW-1:0]     pend_idx_reg, pend_idx_next;
    logic [IW-1:0]     cand_reg, cand_next;
    logic [IW-1:0]     run_len_reg, run_len_next;
    logic              res_status_reg, res_status_next;
    logic [BASE_W-1:0] res_base_reg, res_base_next;

    // scan datapath
    logic          scan_hit;
    logic [IW-1:0] hit_base;
    logic [IW-1:0] run_inc;
    logic [AW-1:0] hit_addr;
    logic [AW-1:0] s_off;

    // store ports
    logic              used_we, used_wdata, used_rdata;
    logic [AW-1:0]     used_waddr, used_raddr;
    logic              size_we;
    logic [AW-1:0]     size_waddr;
    logic [SIZE_W-1:0] size_wdata, size_rdata;

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_base_slot = m_base_reg;

    assign s_off = s_bank ? AW'(SLOTS) : '0;

    // streaming first-fit: track the start and length of the current free run
    always_comb begin
        scan_hit     = 1'b0;
        hit_base     = cand_reg;
        run_len_next = run_len_reg;
        cand_next    = cand_reg;
        run_inc      = run_len_reg + 1'b1;
        if (state_reg == ST_SCAN && pend_reg) begin
            if (used_rdata) begin
                run_len_next = '0;
                cand_next    = pend_idx_reg + 1'b1;
            end else if (len_reg == '0) begin
                // zero size: first free base, nothing gets marked
                scan_hit = 1'b1;
                hit_base = pend_idx_reg;
            end else if (LW'(run_inc) == LW'(len_reg)) begin
                scan_hit = 1'b1;
                hit_base = cand_reg;
            end else begin
                run_len_next = run_inc;
            end
        end else if (state_reg != ST_SCAN) begin
            run_len_next = '0;
            cand_next    = '0;
        end
    end

    assign hit_addr = off_reg + AW'(hit_base);

    always_comb begin
        state_next      = state_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_base_next     = m_base_reg;
        wipe_rsp_next   = wipe_rsp_reg;
        mark_val_next   = mark_val_reg;
        len_next        = len_reg;
        off_next        = off_reg;
        mptr_next       = mptr_reg;
        mcnt_next       = mcnt_reg;
        scan_idx_next   = scan_idx_reg;
        pend_next       = 1'b0;
        pend_idx_next   = pend_idx_reg;
        res_status_next = res_status_reg;
        res_base_next   = res_base_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_WIPE: begin
                mptr_next = mptr_reg + 1'b1;
                if (mptr_reg == AW'(DEPTH - 1)) begin
                    mptr_next  = '0;
                    state_next = wipe_rsp_reg ? ST_RESP : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    len_next        = s_request_size;
                    off_next        = s_off;
                    res_status_next = STAT_DONE;
                    res_base_next   = '0;
                    unique case (psa_action_t'(s_action))
                        ACT_ALLOC: begin
                            scan_idx_next = '0;
                            mark_val_next = 1'b1;
                            state_next    = ST_SCAN;
                        end
                        ACT_FREE: begin
                            mptr_next     = s_off + AW'(s_slot_index);
                            mark_val_next = 1'b0;
                            state_next    = (s_slot_index < SLOTS) ? ST_FREQ : ST_RESP;
                        end
                        ACT_CLEAR: begin
                            mptr_next     = '0;
                            wipe_rsp_next = 1'b1;
                            state_next    = ST_WIPE;
                        end
                        ACT_NOP: begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (scan_idx_reg < IW'(SLOTS)) begin
                    pend_next     = 1'b1;
                    pend_idx_next = scan_idx_reg;
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                if (scan_hit) begin
                    pend_next     = 1'b0;
                    res_base_next = BASE_W'(hit_base);
                    mptr_next     = hit_addr;
                    mcnt_next     = len_reg;
                    state_next    = (len_reg == '0) ? ST_RESP : ST_MARK;
                end else if (!pend_reg && scan_idx_reg >= IW'(SLOTS)) begin
                    res_status_next = STAT_NOSPACE;
                    state_next      = ST_RESP;
                end
            end
            ST_MARK: begin
                mptr_next = mptr_reg + 1'b1;
                mcnt_next = mcnt_reg - 1'b1;
                if (mcnt_reg == SIZE_W'(1)) begin
                    state_next = ST_RESP;
                end
            end
            ST_FREQ: begin
                state_next = ST_FGET;
            end
            ST_FGET: begin
                // recorded runs always lie inside the bank
                mcnt_next  = size_rdata;
                state_next = (size_rdata == '0) ? ST_RESP : ST_MARK;
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_base_next   = res_base_reg;
                    wipe_rsp_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_WIPE;
            m_valid_reg  <= 1'b0;
            wipe_rsp_reg <= 1'b0;
            mptr_reg     <= '0;
            pend_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            wipe_rsp_reg <= wipe_rsp_next;
            mptr_reg     <= mptr_next;
            pend_reg     <= pend_next;
        end
        m_status_reg   <= m_status_next;
        m_base_reg     <= m_base_next;
        mark_val_reg   <= mark_val_next;
        len_reg        <= len_next;
        off_reg        <= off_next;
        mcnt_reg       <= mcnt_next;
        scan_idx_reg   <= scan_idx_next;
        pend_idx_reg   <= pend_idx_next;
        cand_reg       <= cand_next;
        run_len_reg    <= run_len_next;
        res_status_reg <= res_status_next;
        res_base_reg   <= res_base_next;
    end

    // store port muxing
    assign used_we    = (state_reg == ST_WIPE) || (state_reg == ST_MARK);
    assign used_waddr = mptr_reg;
    assign used_wdata = (state_reg == ST_MARK) ? mark_val_reg : 1'b0;
    assign used_raddr = off_reg + AW'(scan_idx_reg);

    assign size_we    = (state_reg == ST_WIPE) || (state_reg == ST_FGET) ||
                        (scan_hit && (len_reg != '0));
    assign size_waddr = (state_reg == ST_SCAN) ? hit_addr : mptr_reg;
    assign size_wdata = (state_reg == ST_SCAN) ? len_reg : '0;

    psa_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_used_ram (
        .aclk  (aclk),
        .we    (used_we),
        .waddr (used_waddr),
        .wdata (used_wdata),
        .raddr (used_raddr),
        .rdata (used_rdata)
    );

    psa_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (DEPTH)
    ) u_size_ram (
        .aclk  (aclk),
        .we    (size_we),
        .waddr (size_waddr),
        .wdata (size_wdata),
        .raddr (mptr_reg),
        .rdata (size_rdata)
    );

    `PSA_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "ready right after a beat")
    `PSA_ASSERT_SAME(a_nospace_zero_base, m_valid && (m_status == STAT_NOSPACE), m_base_slot == '0, "no-space result with nonzero base")
    `PSA_ASSERT_SAME(a_mark_count, state_reg == ST_MARK, mcnt_reg != '0, "mark phase with empty count")
    `PSA_ASSERT_SAME(a_run_below_len, (state_reg == ST_SCAN) && (len_reg != '0), LW'(run_len_reg) < LW'(len_reg), "free run reached length without grant")

endmodule

`default_nettype wire

// ===== hw/rtl/psa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module psa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== tb/palette_slot_allocator_unit_tb.sv =====
// Self-checking testbench for palette_slot_allocator_unit: first-fit allocate, free and
// clear on both palette banks, scored against an in-bench slot map predictor.
// Depends on psa_pkg and the palette_slot_allocator_unit RTL.
`timescale 1ns / 1ps

module palette_slot_allocator_unit_tb;
    import psa_pkg::*;

    localparam int SLOTS            = 512;
    localparam int RANDOM_ITEMS     = 1100;
    localparam int SINK_HOLD_CYCLES = 3000;
    localparam int SETTLE_CYCLES    = 32;
    localparam longint CYCLE_LIMIT  = 8_000_000;

    typedef struct packed {
        logic              status;
        logic [BASE_W-1:0] base_slot;
    } slot_grant_t;

    typedef struct {
        bit                bank;
        logic [BASE_W-1:0] base;
    } live_run_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [ACTION_W-1:0] s_action = '0;
    logic                s_bank = 1'b0;
    logic [SIZE_W-1:0]   s_request_size = '0;
    logic [BASE_W-1:0]   s_slot_index = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_status;
    logic [BASE_W-1:0]   m_base_slot;

    // predictor state: per bank occupancy and recorded run length at each base
    bit                slot_used [2][SLOTS];
    logic [SIZE_W-1:0] run_len   [2][SLOTS];

    slot_grant_t expected_grants[$];
    live_run_t   live_runs[$];
    slot_grant_t grant_want;
    int          error_count = 0;
    longint      cycle_count = 0;
    bit          burst_mode = 1'b0;
    bit          sink_hold_pending = 1'b0;

    palette_slot_allocator_unit #(
        .SLOTS(SLOTS)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_bank         (s_bank),
        .s_request_size (s_request_size),
        .s_slot_index   (s_slot_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_base_slot    (m_base_slot)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("palette_slot_allocator_unit_tb: errors");
            $finish;
        end
    end

    function automatic slot_grant_t predict_slot_request(psa_action_t act, bit bnk,
                                                         logic [SIZE_W-1:0] sz,
                                                         logic [BASE_W-1:0] idx);
        slot_grant_t res;
        int unsigned len;
        int unsigned b;
        bit          fits;
        res.status    = STAT_DONE;
        res.base_slot = '0;
        case (act)
            ACT_ALLOC: begin
                res.status = STAT_NOSPACE;
                len = sz;
                for (int unsigned i = 0; i < SLOTS; i++) begin
                    if (slot_used[bnk][i]) continue;
                    if (len > SLOTS - i) continue;
                    fits = 1'b1;
                    for (int unsigned k = 0; k < len; k++)
                        if (slot_used[bnk][i+k]) fits = 1'b0;
                    if (!fits) continue;
                    for (int unsigned k = 0; k < len; k++)
                        slot_used[bnk][i+k] = 1'b1;
                    run_len[bnk][i] = sz;
                    res.status    = STAT_DONE;
                    res.base_slot = BASE_W'(i);
                    break;
                end
            end
            ACT_FREE: begin
                b = idx;
                if (b < SLOTS) begin
                    len = run_len[bnk][b];
                    if (len > SLOTS - b) len = SLOTS - b;
                    for (int unsigned k = 0; k < len; k++)
                        slot_used[bnk][b+k] = 1'b0;
                    run_len[bnk][b] = '0;
                end
            end
            ACT_CLEAR: begin
                for (int j = 0; j < 2; j++)
                    for (int i = 0; i < SLOTS; i++) begin
                        slot_used[j][i] = 1'b0;
                        run_len[j][i]   = '0;
                    end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic int idle_len();
        int r;
        if (burst_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 20);
        return $urandom_range(40, 600);
    endfunction

    function automatic logic [SIZE_W-1:0] random_run_size();
        int r;
        r = $urandom_range(0, 199);
        if (r < 12)  return '0;
        if (r < 160) return SIZE_W'($urandom_range(1, 8));
        if (r < 186) return SIZE_W'($urandom_range(9, 40));
        if (r < 196) return SIZE_W'($urandom_range(41, 200));
        if (r < 199) return SIZE_W'($urandom_range(201, 512));
        return SIZE_W'($urandom_range(513, 1023));
    endfunction

    // Drive one request beat and return at the edge where it is taken.
    task automatic send_request(psa_action_t act, bit bnk, logic [SIZE_W-1:0] sz,
                                logic [BASE_W-1:0] idx);
        int          gap;
        slot_grant_t res;
        live_run_t   run;
        gap = idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        res = predict_slot_request(act, bnk, sz, idx);
        expected_grants.push_back(res);
        if (act == ACT_ALLOC && res.status == STAT_DONE && sz != 0) begin
            run.bank = bnk;
            run.base = res.base_slot;
            live_runs.push_back(run);
        end else if (act == ACT_FREE) begin
            for (int i = live_runs.size() - 1; i >= 0; i--)
                if (live_runs[i].bank == bnk && live_runs[i].base == idx)
                    live_runs.delete(i);
        end else if (act == ACT_CLEAR) begin
            live_runs.delete();
        end
        s_valid        <= 1'b1;
        s_action       <= act;
        s_bank         <= bnk;
        s_request_size <= sz;
        s_slot_index   <= idx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_grants.size() != 0) @(posedge aclk);
    endtask

    task automatic alloc_req(bit bnk, logic [SIZE_W-1:0] sz);
        send_request(ACT_ALLOC, bnk, sz, BASE_W'($urandom));
    endtask

    task automatic free_req(bit bnk, logic [BASE_W-1:0] idx);
        send_request(ACT_FREE, bnk, SIZE_W'($urandom), idx);
    endtask

    task automatic send_random_request();
        int        r;
        int        k;
        live_run_t run;
        r = $urandom_range(0, 99);
        if (r < 2) begin
            send_request(ACT_CLEAR, 1'($urandom), SIZE_W'($urandom), BASE_W'($urandom));
        end else if (r < 4) begin
            send_request(ACT_NOP, 1'($urandom), SIZE_W'($urandom), BASE_W'($urandom));
        end else if (r < 85 && r >= 50 && live_runs.size() != 0) begin
            k = $urandom_range(0, live_runs.size() - 1);
            run = live_runs[k];
            free_req(run.bank, run.base);
        end else if (r >= 85 && r < 95) begin
            free_req(1'($urandom), BASE_W'($urandom));
        end else begin
            alloc_req(1'($urandom), random_run_size());
        end
    endtask

    // empty banks, whole-bank grant, full bank, oversized requests
    task automatic test_empty_banks();
        alloc_req(1'b0, 10'd0);
        alloc_req(1'b1, 10'd512);
        alloc_req(1'b1, 10'd1);
        alloc_req(1'b1, 10'd0);
        free_req(1'b1, 9'd0);
        alloc_req(1'b0, 10'd513);
        alloc_req(1'b0, 10'd1023);
    endtask

    // holes, first fit across them, frees of bases with no recorded run
    task automatic test_first_fit();
        alloc_req(1'b0, 10'd3);
        alloc_req(1'b0, 10'd5);
        alloc_req(1'b0, 10'd1);
        free_req(1'b0, 9'd3);
        alloc_req(1'b0, 10'd6);
        alloc_req(1'b0, 10'd4);
        alloc_req(1'b0, 10'd2);
        alloc_req(1'b0, 10'd0);
        free_req(1'b0, 9'd4);
        free_req(1'b0, 9'd511);
    endtask

    task automatic test_clear_and_idle_action();
        send_request(ACT_NOP, 1'b1, 10'd1023, 9'd511);
        send_request(ACT_CLEAR, 1'b0, 10'd0, 9'd0);
        alloc_req(1'b0, 10'd511);
        alloc_req(1'b0, 10'd2);
        alloc_req(1'b0, 10'd1);
        free_req(1'b0, 9'd0);
    endtask

    task automatic test_random_traffic();
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 150 == 0) burst_mode = ($urandom_range(0, 9) < 3);
            if ($urandom_range(0, 99) == 0) wait_drained();
            send_random_request();
        end
        burst_mode = 1'b0;
    endtask

    // sink stalls long while requests keep coming, so the input backs up
    task automatic test_output_backpressure();
        burst_mode = 1'b1;
        sink_hold_pending = 1'b1;
        for (int n = 0; n < 12; n++) begin
            if (n % 3 == 0) alloc_req(1'($urandom), SIZE_W'($urandom_range(1, 4)));
            else send_random_request();
        end
        burst_mode = 1'b0;
    endtask

    task automatic test_drain_pause();
        for (int n = 0; n < 3; n++) send_random_request();
        wait_drained();
        for (int n = 0; n < 3; n++) send_random_request();
    endtask

    initial begin : result_sink
        int n;
        forever begin
            @(posedge aclk);
            if (sink_hold_pending) begin
                sink_hold_pending = 1'b0;
                m_ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (burst_mode) begin
                m_ready <= 1'b1;
            end else if (m_valid) begin
                n = idle_len();
                if (n > 0) begin
                    m_ready <= 1'b0;
                    repeat (n) @(posedge aclk);
                end
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 2) != 0);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_grants.size() == 0) begin
                $error("unexpected result beat: status %0d base_slot %0d",
                       m_status, m_base_slot);
                error_count++;
            end else begin
                grant_want = expected_grants.pop_front();
                if (m_status !== grant_want.status) begin
                    $error("status: expected %0d, actual %0d", grant_want.status, m_status);
                    error_count++;
                end
                if (m_base_slot !== grant_want.base_slot) begin
                    $error("base_slot: expected %0d, actual %0d",
                           grant_want.base_slot, m_base_slot);
                    error_count++;
                end
            end
        end
    end

    initial begin
        for (int j = 0; j < 2; j++)
            for (int i = 0; i < SLOTS; i++) begin
                slot_used[j][i] = 1'b0;
                run_len[j][i]   = '0;
            end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_banks();
        test_first_fit();
        test_clear_and_idle_action();
        test_output_backpressure();
        test_drain_pause();
        test_random_traffic();
        test_drain_pause();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0 && expected_grants.size() == 0)
            $display("palette_slot_allocator_unit_tb: clean");
        else
            $display("palette_slot_allocator_unit_tb: errors");
        $finish;
    end

endmodule
